FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the project checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define RGBCC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define RGBCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is checked through reset as well.
`define RGBCC_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/rgbcc_pkg.sv
// ----------------------------------------------------------------------------
// rgbcc_pkg
// Types, constants and helper functions of the RGB color cycle controller.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbcc_pkg;

  // Number of modes and the top fade speed.
  localparam int unsigned MODE_COUNT = 8;
  localparam int unsigned MAX_SPEED  = 10;

  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned SPEED_W = 4;
  localparam int unsigned CHAN_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_LEVEL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_LEVEL      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_OUTPUTS = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [LEVEL_W-1:0] BRIGHT_RESET = 8'd255;
  localparam logic [LEVEL_W-1:0] DIM_RESET    = 8'd50;

  // Mode codes.
  localparam logic [MODE_W-1:0] MODE_FADE   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_RED    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_GREEN  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_BLUE   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PURPLE = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CYAN   = 3'd5;
  localparam logic [MODE_W-1:0] MODE_YELLOW = 3'd6;
  localparam logic [MODE_W-1:0] MODE_WHITE  = 3'd7;

  // Channel codes.
  localparam logic [CHAN_W-1:0] CHAN_RED   = 2'd0;
  localparam logic [CHAN_W-1:0] CHAN_GREEN = 2'd1;
  localparam logic [CHAN_W-1:0] CHAN_BLUE  = 2'd2;

  // Fade state: three channel levels plus the rising and falling pointers.
  typedef struct packed {
    logic [2:0][LEVEL_W-1:0] levels;
    logic [CHAN_W-1:0]       rising;
    logic [CHAN_W-1:0]       falling;
  } fade_state_t;

  // Next channel in the order red, green, blue, wrapping to red.
  function automatic logic [CHAN_W-1:0] next_channel(input logic [CHAN_W-1:0] c);
    next_channel = (c >= CHAN_BLUE) ? CHAN_RED : c + 2'd1;
  endfunction

  // Channel enables {blue, green, red} of a fixed color mode.
  function automatic logic [2:0] color_mask(input logic [MODE_W-1:0] mode);
    logic [2:0] m;
    unique case (mode)
      MODE_RED:    m = 3'b001;
      MODE_GREEN:  m = 3'b010;
      MODE_BLUE:   m = 3'b100;
      MODE_PURPLE: m = 3'b101;
      MODE_CYAN:   m = 3'b110;
      MODE_YELLOW: m = 3'b011;
      MODE_WHITE:  m = 3'b111;
      default:     m = 3'b000;
    endcase
    color_mask = m;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/rgbcc_fade_step.sv
// ----------------------------------------------------------------------------
// rgbcc_fade_step
// One fade tick: raise one channel, lower another, clamp and rotate pointers.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbcc_fade_step
  import rgbcc_pkg::*;
(
  input  fade_state_t        cur,
  input  logic [SPEED_W-1:0] speed,
  input  logic [LEVEL_W-1:0] ceiling,
  output fade_state_t        nxt
);

  logic [CHAN_W-1:0]       up;
  logic [CHAN_W-1:0]       dn;
  logic signed [9:0]       lv [3];
  logic signed [9:0]       spd_s;
  logic signed [9:0]       ceil_s;
  logic                    up_over;
  logic                    dn_under;
  logic [CHAN_W-1:0]       up_nxt;
  logic [CHAN_W-1:0]       dn_nxt;

  // Pointers reduce modulo three; only the unused code needs folding.
  assign up     = (cur.rising  == 2'd3) ? CHAN_RED : cur.rising;
  assign dn     = (cur.falling == 2'd3) ? CHAN_RED : cur.falling;
  assign spd_s  = signed'({6'd0, speed});
  assign ceil_s = signed'({2'd0, ceiling});

  // Rise first, then fall, then the ceiling check, then the zero check.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lv[i] = signed'({2'd0, cur.levels[i]});
      if (up == CHAN_W'(i)) lv[i] = lv[i] + spd_s;
      if (dn == CHAN_W'(i)) lv[i] = lv[i] - spd_s;
    end
    up_over = lv[up] > ceil_s;
    up_nxt  = up;
    if (up_over) begin
      lv[up] = ceil_s;
      up_nxt = next_channel(up);
    end
    dn_under = lv[dn] < 10'sd0;
    dn_nxt   = dn;
    if (dn_under) begin
      lv[dn] = 10'sd0;
      dn_nxt = next_channel(dn);
    end
    for (int i = 0; i < 3; i++) begin
      if (lv[i] < 10'sd0) begin
        nxt.levels[i] = '0;
      end else if (lv[i] > 10'sd255) begin
        nxt.levels[i] = 8'd255;
      end else begin
        nxt.levels[i] = lv[i][LEVEL_W-1:0];
      end
    end
    nxt.rising  = up_nxt;
    nxt.falling = dn_nxt;
  end

endmodule

`default_nettype wire

FILE: hdl/rgb_color_cycle_mode_controller.sv
// A request accepted at a clock edge is loaded into the output register at that edge.
// Throughput: one request per cycle; the state update and output register form one stage.
// The input stalls only while a result waits in the output register and the sink stalls.
// Reset (rst_n low, synchronous) restores fade mode, bright, speed 1, red at 255,
// the register defaults 255 / 50 / no inversion, and empties the output register.
// ----------------------------------------------------------------------------
// rgb_color_cycle_mode_controller
// Mode button handling, color wheel fade and fixed colors for two LED groups.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_color_cycle_mode_controller
  import rgbcc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // Tick requests
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_button_pressed,
  // Results
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [LEVEL_W-1:0]   out_red_level,
  output logic [LEVEL_W-1:0]   out_green_level,
  output logic [LEVEL_W-1:0]   out_blue_level,
  output logic                 out_second_group_on,
  // Configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LEVEL_W-1:0]   cfg_data
);

  logic [LEVEL_W-1:0] bright_r;
  logic [LEVEL_W-1:0] dim_level_r;
  logic               invert_r;

  logic [MODE_W-1:0]  mode_r,  mode_nxt;
  logic               dim_r,   dim_nxt;
  logic [SPEED_W-1:0] speed_r, speed_nxt;
  fade_state_t        fade_r,  fade_nxt;
  fade_state_t        fade_pre;
  fade_state_t        fade_adv;

  logic               out_valid_r;
  logic [LEVEL_W-1:0] red_r, green_r, blue_r;
  logic               second_r;

  logic               accept;
  logic [MODE_W:0]    mode_inc;
  logic [SPEED_W:0]   speed_inc;
  logic [LEVEL_W-1:0] ceiling;
  logic [2:0]         mask;
  logic [LEVEL_W-1:0] red_v, green_v, blue_v;

  // Handshake: accept whenever the output register is free or draining.
  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_r    <= BRIGHT_RESET;
      dim_level_r <= DIM_RESET;
      invert_r    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BRIGHT_LEVEL:   bright_r    <= cfg_data;
        CFG_DIM_LEVEL:      dim_level_r <= cfg_data;
        CFG_INVERT_OUTPUTS: invert_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Button press: advance mode, toggle brightness on wrap, bump speed on return to bright.
  always_comb begin
    mode_inc  = {1'b0, mode_r} + 4'd1;
    speed_inc = {1'b0, speed_r} + 5'd1;
    mode_nxt  = mode_r;
    dim_nxt   = dim_r;
    speed_nxt = speed_r;
    if (in_button_pressed) begin
      if (mode_inc >= (MODE_W+1)'(MODE_COUNT)) begin
        mode_nxt = MODE_FADE;
        if (dim_r) begin
          dim_nxt   = 1'b0;
          speed_nxt = (speed_inc > (SPEED_W+1)'(MAX_SPEED)) ? SPEED_W'(1)
                                                            : speed_inc[SPEED_W-1:0];
        end else begin
          dim_nxt = 1'b1;
        end
      end else begin
        mode_nxt = mode_inc[MODE_W-1:0];
      end
    end
  end

  assign ceiling = dim_nxt ? dim_level_r : bright_r;

  // Entering fade mode reloads red at the ceiling.
  always_comb begin
    fade_pre = fade_r;
    if (in_button_pressed && mode_nxt == MODE_FADE) begin
      fade_pre.levels[CHAN_RED]   = ceiling;
      fade_pre.levels[CHAN_GREEN] = '0;
      fade_pre.levels[CHAN_BLUE]  = '0;
      fade_pre.rising             = CHAN_GREEN;
      fade_pre.falling            = CHAN_RED;
    end
  end

  rgbcc_fade_step u_fade_step (
    .cur     (fade_pre),
    .speed   (speed_nxt),
    .ceiling (ceiling),
    .nxt     (fade_adv)
  );

  // Result levels: fade levels in fade mode, masked ceiling otherwise.
  always_comb begin
    mask = color_mask(mode_nxt);
    if (mode_nxt == MODE_FADE) begin
      fade_nxt = fade_adv;
      red_v    = fade_adv.levels[CHAN_RED];
      green_v  = fade_adv.levels[CHAN_GREEN];
      blue_v   = fade_adv.levels[CHAN_BLUE];
    end else begin
      fade_nxt = fade_pre;
      red_v    = mask[0] ? ceiling : '0;
      green_v  = mask[1] ? ceiling : '0;
      blue_v   = mask[2] ? ceiling : '0;
    end
    if (invert_r) begin
      red_v   = ~red_v;
      green_v = ~green_v;
      blue_v  = ~blue_v;
    end
  end

  // Animation state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_FADE;
      dim_r   <= 1'b0;
      speed_r <= SPEED_W'(1);
      fade_r.levels[CHAN_RED]   <= 8'd255;
      fade_r.levels[CHAN_GREEN] <= '0;
      fade_r.levels[CHAN_BLUE]  <= '0;
      fade_r.rising  <= CHAN_GREEN;
      fade_r.falling <= CHAN_RED;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      dim_r   <= dim_nxt;
      speed_r <= speed_nxt;
      fade_r  <= fade_nxt;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      red_r    <= red_v;
      green_r  <= green_v;
      blue_r   <= blue_v;
      second_r <= !dim_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_red_level       = red_r;
  assign out_green_level     = green_r;
  assign out_blue_level      = blue_r;
  assign out_second_group_on = second_r;

endmodule

`default_nettype wire

FILE: hdl/rgbcc_checker.sv
// ----------------------------------------------------------------------------
// rgbcc_checker
// Port-level assertions for the RGB color cycle controller, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rgbcc_checker
  import rgbcc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [LEVEL_W-1:0] out_red_level,
  input  logic [LEVEL_W-1:0] out_green_level,
  input  logic [LEVEL_W-1:0] out_blue_level,
  input  logic               out_second_group_on
);

  logic               out_held;
  logic               in_taken;
  logic [3*LEVEL_W:0] out_bus;

  assign out_held = out_valid && out_stall;
  assign in_taken = in_valid && !in_stall;
  assign out_bus  = {out_red_level, out_green_level, out_blue_level, out_second_group_on};

  // A stalled result stays and keeps its payload.
  `RGBCC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_held, out_valid && $stable(out_bus), "result moved")

  // The input side stalls only behind a held result.
  `RGBCC_ASSERT_IMPL(a_stall_cause, clk, rst_n, in_stall, out_held, "stall without held result")

  // Every accepted request produces a result in the next cycle.
  `RGBCC_ASSERT_NEXT(a_result_follows, clk, rst_n, in_taken, out_valid, "no result after request")

  // Reset empties the output register.
  `RGBCC_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid, "result valid after reset")

endmodule

bind rgb_color_cycle_mode_controller rgbcc_checker u_rgbcc_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_red_level       (out_red_level),
  .out_green_level     (out_green_level),
  .out_blue_level      (out_blue_level),
  .out_second_group_on (out_second_group_on)
);

`default_nettype wire

FILE: sim/rgb_color_cycle_mode_controller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_color_cycle_mode_controller_tb
// Self-checking bench for the mode controller. It starts with a short list of
// ticks and register writes whose LED levels are known by hand. Random phases
// follow with new register settings, press runs, fade runs and noise ticks.
// Every random result is checked against a behavioral model of the modes, the
// bright/dim toggle, the fade speed and the color wheel fade.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_color_cycle_mode_controller_tb;
  import rgbcc_pkg::*;

  localparam int unsigned RANDOM_TICKS = 390;
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned NUM_ROWS     = 28;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  // One set of LED drive levels, in the order of the output ports.
  typedef struct packed {
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
    logic               group2_on;
  } led_result_t;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [LEVEL_W-1:0] reg_val;
    bit                 press;
    bit                 golden_ok;
    led_result_t        golden;
  } stim_row_t;

  typedef enum logic [1:0] {SINK_NONE, SINK_RANDOM, SINK_PERIODIC, SINK_HEAVY} sink_mode_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_button_pressed;
  logic out_valid;
  logic out_stall;
  logic [LEVEL_W-1:0] out_red_level;
  logic [LEVEL_W-1:0] out_green_level;
  logic [LEVEL_W-1:0] out_blue_level;
  logic out_second_group_on;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LEVEL_W-1:0] cfg_data;

  // Hand-checked value that travels with a directed request.
  bit          row_golden_ok;
  led_result_t row_golden;

  // Model of the controller state and its registers.
  logic [MODE_W-1:0]  st_mode;
  bit                 st_dim;
  logic [SPEED_W-1:0] st_speed;
  logic [LEVEL_W-1:0] st_level [3];
  logic [CHAN_W-1:0]  st_rise;
  logic [CHAN_W-1:0]  st_fall;
  logic [LEVEL_W-1:0] reg_bright;
  logic [LEVEL_W-1:0] reg_dim;
  bit                 reg_invert;

  led_result_t expected_leds [$];
  int unsigned fault_count;
  int unsigned cycle_count;
  int unsigned tick_count;
  int unsigned burst_left;
  bit          sender_gaps;
  sink_mode_t  sink_mode;
  logic [MODE_W-1:0] gen_mode;
  stim_row_t   directed_rows [NUM_ROWS];

  rgb_color_cycle_mode_controller uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_button_pressed   (in_button_pressed),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_red_level       (out_red_level),
    .out_green_level     (out_green_level),
    .out_blue_level      (out_blue_level),
    .out_second_group_on (out_second_group_on),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Advance the model by one tick and return the LED levels it drives.
  function automatic led_result_t next_led_drive(input bit press);
    int lv [3];
    int up, dn, ceil_lvl, m, i;
    logic [LEVEL_W-1:0] ceil8;
    led_result_t res;
    if (press) begin
      m = int'(st_mode) + 1;
      if (m >= int'(MODE_COUNT)) begin
        m = 0;
        if (st_dim) begin
          st_dim   = 1'b0;
          st_speed = st_speed + 1'b1;
          if (st_speed > MAX_SPEED) st_speed = 1;
        end else begin
          st_dim = 1'b1;
        end
      end
      st_mode = m[MODE_W-1:0];
      // Entering fade mode restarts the wheel at red.
      if (st_mode == MODE_FADE) begin
        st_level[CHAN_RED]   = st_dim ? reg_dim : reg_bright;
        st_level[CHAN_GREEN] = '0;
        st_level[CHAN_BLUE]  = '0;
        st_rise = CHAN_GREEN;
        st_fall = CHAN_RED;
      end
    end
    ceil8    = st_dim ? reg_dim : reg_bright;
    ceil_lvl = int'(ceil8);
    res      = '0;
    case (st_mode)
      MODE_FADE: begin
        // Rise first, then fall, then clamp each end and move its pointer on.
        up = int'(st_rise) % 3;
        dn = int'(st_fall) % 3;
        for (i = 0; i < 3; i++) lv[i] = int'(st_level[i]);
        lv[up] += int'(st_speed);
        lv[dn] -= int'(st_speed);
        if (lv[up] > ceil_lvl) begin
          lv[up] = ceil_lvl;
          up = (up >= int'(CHAN_BLUE)) ? int'(CHAN_RED) : up + 1;
        end
        if (lv[dn] < 0) begin
          lv[dn] = 0;
          dn = (dn >= int'(CHAN_BLUE)) ? int'(CHAN_RED) : dn + 1;
        end
        for (i = 0; i < 3; i++) begin
          if (lv[i] < 0) lv[i] = 0;
          if (lv[i] > 255) lv[i] = 255;
          st_level[i] = lv[i][LEVEL_W-1:0];
        end
        st_rise   = up[CHAN_W-1:0];
        st_fall   = dn[CHAN_W-1:0];
        res.red   = st_level[CHAN_RED];
        res.green = st_level[CHAN_GREEN];
        res.blue  = st_level[CHAN_BLUE];
      end
      MODE_RED:    res.red = ceil8;
      MODE_GREEN:  res.green = ceil8;
      MODE_BLUE:   res.blue = ceil8;
      MODE_PURPLE: begin
        res.red  = ceil8;
        res.blue = ceil8;
      end
      MODE_CYAN: begin
        res.green = ceil8;
        res.blue  = ceil8;
      end
      MODE_YELLOW: begin
        res.red   = ceil8;
        res.green = ceil8;
      end
      MODE_WHITE: begin
        res.red   = ceil8;
        res.green = ceil8;
        res.blue  = ceil8;
      end
      default: ;
    endcase
    if (reg_invert) begin
      res.red   = ~res.red;
      res.green = ~res.green;
      res.blue  = ~res.blue;
    end
    res.group2_on = !st_dim;
    return res;
  endfunction

  // Scoreboard: check results against the oldest expectation, then predict.
  always @(posedge clk) begin : scoreboard
    led_result_t seen;
    led_result_t want;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid && !out_stall) begin
      seen = {out_red_level, out_green_level, out_blue_level, out_second_group_on};
      if (expected_leds.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("unexpected result r=%0d g=%0d b=%0d grp2=%0d", seen.red, seen.green,
                   seen.blue, seen.group2_on);
      end else begin
        want = expected_leds.pop_front();
        if (seen.red !== want.red || seen.green !== want.green ||
            seen.blue !== want.blue || seen.group2_on !== want.group2_on) begin
          fault_count++;
          if (fault_count <= 10)
            $display("mismatch: expected r=%0d g=%0d b=%0d grp2=%0d, got r=%0d g=%0d b=%0d grp2=%0d",
                     want.red, want.green, want.blue, want.group2_on,
                     seen.red, seen.green, seen.blue, seen.group2_on);
        end
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      want = next_led_drive(in_button_pressed);
      expected_leds.push_back(row_golden_ok ? row_golden : want);
    end
  end

  // Timeout guard.
  always @(posedge clk) begin
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result sink stall pattern.
  always @(negedge clk) begin
    case (sink_mode)
      SINK_NONE:     out_stall <= 1'b0;
      SINK_RANDOM:   out_stall <= ($urandom_range(0, 99) < 30);
      SINK_PERIODIC: out_stall <= ((cycle_count % 7) < 3);
      default:       out_stall <= ($urandom_range(0, 99) < 75);
    endcase
  end

  // Send one tick request; called and returning at a falling edge.
  task automatic send_tick(input bit press, input bit golden_ok, input led_result_t golden);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (sender_gaps) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end
    end
    burst_left--;
    in_valid          <= 1'b1;
    in_button_pressed <= press;
    row_golden_ok     <= golden_ok;
    row_golden        <= golden;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (press) gen_mode = gen_mode + 1'b1;
    tick_count++;
    @(negedge clk);
  endtask

  // Hold off the sender until every expected result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_leds.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Write one configuration register and mirror it in the model.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEVEL_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_BRIGHT_LEVEL:   reg_bright = val;
      CFG_DIM_LEVEL:      reg_dim = val;
      CFG_INVERT_OUTPUTS: reg_invert = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Ceiling values weighted toward the extremes and small fast-clamping levels.
  function automatic logic [LEVEL_W-1:0] pick_level();
    case ($urandom_range(0, 4))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'($urandom_range(1, 12));
      3:       return 8'($urandom_range(13, 60));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    int unsigned phase_end;
    int unsigned stop_at;
    int          pick;
    int          n;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_button_pressed = 1'b0;
    out_stall         = 1'b0;
    cfg_valid         = 1'b0;
    cfg_index         = CFG_BRIGHT_LEVEL;
    cfg_data          = '0;
    row_golden_ok     = 1'b0;
    row_golden        = '0;
    fault_count       = 0;
    cycle_count       = 0;
    tick_count        = 0;
    burst_left        = 0;
    sender_gaps       = 1'b0;
    sink_mode         = SINK_NONE;
    gen_mode          = MODE_FADE;
    st_mode           = MODE_FADE;
    st_dim            = 1'b0;
    st_speed          = 1;
    st_level[CHAN_RED]   = 8'd255;
    st_level[CHAN_GREEN] = 8'd0;
    st_level[CHAN_BLUE]  = 8'd0;
    st_rise           = CHAN_GREEN;
    st_fall           = CHAN_RED;
    reg_bright        = BRIGHT_RESET;
    reg_dim           = DIM_RESET;
    reg_invert        = 1'b0;

    // Directed list: full mode round bright, dim round, speed step, inversion.
    directed_rows = '{
      '{ROW_TICK, CFG_BRIGHT_LEVEL, 8'd0, 1'b0, 1'b1, {8'd254, 8'd1,   8'd0,   1'b1}},
      '{ROW_TICK, CFG_BRIGHT_LEVEL, 8'd0, 1'b1, 1'b1, {8'd255, 8'd0,   8'd0,   1'b1}},
      '{ROW_TICK, CFG_BRIGHT_LEVEL, 8'd0, 1'b1, 1'b1, {8'd0,   8'd255, 8'd0,   1'b1}},
      '{ROW_TICK, CFG_BRIGHT_LEVEL, 8'd0, 1'b1, 1'b1, {8'd0,   8'd0,   8'd255, 1'b1}},
      '{ROW_TICK, CFG_BRIGHT_LEVEL, 8'd0, 1'b1, 1'b1, {8'd255, 8'd0,   8'd255, 1'b1}},
      '{ROW_TICK, CFG_BRIGHT_LEVEL, 8'd0, 1'b1, 1'b1, {8'd0,   8'd255, 8'd255, 1'b1}},
      '{ROW_TICK, CFG_BRIGHT_LEVEL, 8'd0, 1'b1, 1'b1, {8'd255, 8'd255, 8'd0,   1'b1}},
      '{ROW_TICK, CFG_BRIGHT_LEVEL, 8'd0, 1'b1, 1'b1, {8'd255, 8'd255, 8'd255, 1'b1}},
      '{ROW_TICK, CFG_BRIGHT_LEVEL, 8'd0, 1'b1, 1'b1, {8'd49,  8'd1,   8'd0,   1'b0}},
      '{ROW_TICK, CFG_BRIGHT_LEVEL, 8'd0, 1'b0, 1'b1, {8'd48,  8'd2,   8'd0,   1'b0}},
      '{ROW_TICK, CFG_BRIGHT_LEVEL, 8'd0, 1'b1, 1'b1, {8'd50,  8'd0,   8'd0,   1'b0}},
      '{ROW_TICK, CFG_BRIGHT_LEVEL, 8'd0, 1'b1, 1'b1, {8'd0,   8'd50,  8'd0,   1'b0}},
      '{ROW_TICK, CFG_BRIGHT_LEVEL, 8'd0, 1'b1, 1'b1, {8'd0,   8'd0,   8'd50,  1'b0}},
      '{ROW_TICK, CFG_BRIGHT_LEVEL, 8'd0, 1'b1, 1'b1, {8'd50,  8'd0,   8'd50,  1'b0}},
      '{ROW_TICK, CFG_BRIGHT_LEVEL, 8'd0, 1'b1, 1'b1, {8'd0,   8'd50,  8'd50,  1'b0}},
      '{ROW_TICK, CFG_BRIGHT_LEVEL, 8'd0, 1'b1, 1'b1, {8'd50,  8'd50,  8'd0,   1'b0}},
      '{ROW_TICK, CFG_BRIGHT_LEVEL, 8'd0, 1'b1, 1'b1, {8'd50,  8'd50,  8'd50,  1'b0}},
      '{ROW_TICK, CFG_BRIGHT_LEVEL, 8'd0, 1'b1, 1'b1, {8'd253, 8'd2,   8'd0,   1'b1}},
      '{ROW_TICK, CFG_BRIGHT_LEVEL, 8'd0, 1'b0, 1'b1, {8'd251, 8'd4,   8'd0,   1'b1}},
      '{ROW_CFG,  CFG_INVERT_OUTPUTS, 8'd1, 1'b0, 1'b0, '0},
      '{ROW_TICK, CFG_BRIGHT_LEVEL, 8'd0, 1'b1, 1'b1, {8'd0,   8'd255, 8'd255, 1'b1}},
      '{ROW_CFG,  CFG_BRIGHT_LEVEL, 8'd0, 1'b0, 1'b0, '0},
      '{ROW_TICK, CFG_BRIGHT_LEVEL, 8'd0, 1'b1, 1'b1, {8'd255, 8'd255, 8'd255, 1'b1}},
      '{ROW_CFG,  CFG_INVERT_OUTPUTS, 8'd0, 1'b0, 1'b0, '0},
      '{ROW_TICK, CFG_BRIGHT_LEVEL, 8'd0, 1'b1, 1'b1, {8'd0,   8'd0,   8'd0,   1'b1}},
      '{ROW_CFG,  CFG_DIM_LEVEL, 8'd255, 1'b0, 1'b0, '0},
      '{ROW_CFG,  CFG_BRIGHT_LEVEL, 8'd255, 1'b0, 1'b0, '0},
      '{ROW_TICK, CFG_BRIGHT_LEVEL, 8'd0, 1'b0, 1'b1, {8'd0,   8'd0,   8'd255, 1'b1}}
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part.
    sink_mode = SINK_RANDOM;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        drain_results();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      end else begin
        send_tick(directed_rows[i].press, directed_rows[i].golden_ok, directed_rows[i].golden);
      end
    end

    // Random phases, each with fresh registers and its own idling style.
    stop_at = tick_count + RANDOM_TICKS;
    while (tick_count < stop_at) begin
      drain_results();
      write_reg(CFG_BRIGHT_LEVEL, pick_level());
      write_reg(CFG_DIM_LEVEL, pick_level());
      write_reg(CFG_INVERT_OUTPUTS, {7'($urandom_range(0, 127)), 1'($urandom_range(0, 1))});
      if ($urandom_range(0, 3) == 0) write_reg(CFG_UNMAPPED, 8'($urandom_range(0, 255)));
      sink_mode   = sink_mode_t'($urandom_range(0, 3));
      sender_gaps = ($urandom_range(0, 2) != 0);
      burst_left  = 0;
      phase_end   = tick_count + $urandom_range(40, 90);
      while (tick_count < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          // Run of presses through modes and bright/dim rounds.
          repeat ($urandom_range(1, 24)) send_tick(1'b1, 1'b0, '0);
        end else if (pick < 75) begin
          // Step to fade mode, then let the wheel run.
          while (gen_mode != MODE_FADE) send_tick(1'b1, 1'b0, '0);
          repeat ($urandom_range(3, 30)) send_tick(1'b0, 1'b0, '0);
        end else if (pick < 90) begin
          repeat ($urandom_range(1, 4)) send_tick(1'($urandom_range(0, 1)), 1'b0, '0);
        end else begin
          // Press up to seven times, then hold the reached mode for a few ticks.
          n = $urandom_range(1, 7);
          repeat (n) send_tick(1'b1, 1'b0, '0);
          repeat ($urandom_range(2, 6)) send_tick(1'b0, 1'b0, '0);
        end
      end
    end

    // Wait for the last results, then report.
    drain_results();
    repeat (4) @(negedge clk);
    if (fault_count == 0 && expected_leds.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: rgb_color_cycle_mode_controller.f
+incdir+hdl
hdl/rgbcc_pkg.sv
hdl/rgbcc_fade_step.sv
hdl/rgb_color_cycle_mode_controller.sv
hdl/rgbcc_checker.sv
sim/rgb_color_cycle_mode_controller_tb.sv
